[src/qmm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad motor mixer package
// Shared fixed-point constants, widths, register indexes and types for the
// X-frame motor mixer with smoothing and clip feedforward.
// ----------------------------------------------------------------------------
package qmm_pkg;

    // Fixed-point format of every Q value on the ports
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int TENTH_Q   = (ONE_Q + 5) / 10;
    localparam int MILLI_Q   = (ONE_Q + 500) / 1000;

    // Field widths
    localparam int STICK_W = 15;
    localparam int CMD_W   = 16;
    localparam int THR_W   = 16;
    localparam int OUT_W   = 15;
    localparam int CAP_W   = 15;
    localparam int CARRY_W = 15;

    // Internal arithmetic widths
    localparam int SUM_W   = 19;   // raw mix before saturation
    localparam int MIX_W   = 18;   // saturated mix and filter taps
    localparam int HSUM_W  = 20;   // x + 2*prev + prev2
    localparam int CLIP_W  = 19;   // filtered value plus carry

    // Stick rescale: floor(n * 10 / 9) as a multiply by a reciprocal of 9
    localparam int SCALED_W   = 19;
    localparam int DIV9_SHIFT = 23;
    localparam int DIV9_W     = 20;
    localparam int DIV9_M     = ((1 << DIV9_SHIFT) + 8) / 9;
    localparam int PROD_W     = SCALED_W + DIV9_W;

    // Saturation limits of the mix
    localparam logic signed [SUM_W-1:0] MIX_HI = SUM_W'((1 << (MIX_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MIX_LO = SUM_W'(-(1 << (MIX_W - 1)));

    // Configuration register indexes (word address)
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_CAP      = 2'd2;
    localparam int CLIP_CAP_RESET = 8192;

    typedef struct packed {
        logic             filter_en;
        logic             clip_en;
        logic [CAP_W-1:0] clip_cap;
    } cfg_t;

    // Control handed from the top level to each motor channel
    typedef struct packed {
        logic advance;
        logic motors_off;
        cfg_t cfg;
    } motor_ctl_t;

    // Contents of the input stage
    typedef struct packed {
        logic                    valid;
        logic                    motors_off;
        logic [THR_W-1:0]        throttle;
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] yaw;
    } tick_t;

    // Saturate a raw mix sum to the 18-bit signed range
    function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [SUM_W-1:0] s);
        logic signed [MIX_W-1:0] r;
        if (s > MIX_HI) begin
            r = MIX_HI[MIX_W-1:0];
        end else if (s < MIX_LO) begin
            r = MIX_LO[MIX_W-1:0];
        end else begin
            r = s[MIX_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/quad_motor_mix_filter_clip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad motor mixer with filter and clip feedforward
// Top level: configuration registers, X-frame mix, four motor channels and
// the output register.
// ----------------------------------------------------------------------------
// The block accepts one control tick per clock while results are taken, and
// returns one result per tick. Its result passes through the input register
// and then the output register, from which it is taken when the output side
// is not stalled. The input stage holds the rescaled
// throttle, whose divide by nine is a single reciprocal multiply; the output
// stage takes the mix, the Hann filter and the clip feedforward of all four
// motors in one pass. The input register takes a request whenever it is
// empty or the output register is free or being emptied, so ticks flow back
// to back while results are taken; while a result waits, one more tick can
// still be held, and the input stalls only when both registers are full.
// Filter history and carried excess reset to zero; configuration is written
// over the APB port.
// ----------------------------------------------------------------------------
module quad_motor_mix_filter_clip
    import qmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: throttle_stick[14:0], roll_cmd[30:15], pitch_cmd[46:31],
    //          yaw_cmd[62:47], failsafe[63]
    input  logic [63:0] s_tdata,
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: motor_front_left[14:0], motor_front_right[29:15],
    //          motor_back_right[44:30], motor_back_left[59:45],
    //          motors_on[60], zero[63:61]
    output logic [63:0] m_tdata,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NMOT = 4;

    cfg_t                    cfg_reg;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    tick_t                   tick;
    logic                    out_free;
    logic                    advance;
    motor_ctl_t              motor_ctl;
    logic signed [SUM_W-1:0] t_ext;
    logic signed [SUM_W-1:0] r_ext;
    logic signed [SUM_W-1:0] p_ext;
    logic signed [SUM_W-1:0] y_ext;
    logic signed [MIX_W-1:0] mix [NMOT];
    logic [OUT_W-1:0]        motor [NMOT];
    logic                    m_valid_reg;
    logic [60:0]             m_data_reg;

    // APB configuration registers
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_en <= 1'b0;
            cfg_reg.clip_en   <= 1'b0;
            cfg_reg.clip_cap  <= CAP_W'(CLIP_CAP_RESET);
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_FILTER_ENABLE: cfg_reg.filter_en <= pwdata[0];
                REG_CLIP_ENABLE:   cfg_reg.clip_en   <= pwdata[0];
                REG_CLIP_CAP:      cfg_reg.clip_cap  <= pwdata[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FILTER_ENABLE: prdata = 32'(cfg_reg.filter_en);
            REG_CLIP_ENABLE:   prdata = 32'(cfg_reg.clip_en);
            REG_CLIP_CAP:      prdata = 32'(cfg_reg.clip_cap);
            default:           prdata = '0;
        endcase
    end

    // Input stage
    qmm_throttle u_throttle (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .tick     (tick)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = tick.valid && out_free;

    always_comb begin
        motor_ctl.advance    = advance;
        motor_ctl.motors_off = tick.motors_off;
        motor_ctl.cfg        = cfg_reg;
    end

    // X-frame mix, saturated to the 18-bit signed range
    always_comb begin
        t_ext  = SUM_W'({1'b0, tick.throttle});
        r_ext  = SUM_W'(tick.roll);
        p_ext  = SUM_W'(tick.pitch);
        y_ext  = SUM_W'(tick.yaw);
        mix[0] = sat_mix(t_ext + r_ext - p_ext - y_ext);
        mix[1] = sat_mix(t_ext - r_ext - p_ext + y_ext);
        mix[2] = sat_mix(t_ext - r_ext + p_ext - y_ext);
        mix[3] = sat_mix(t_ext + r_ext + p_ext + y_ext);
    end

    // One channel per motor: front left, front right, back right, back left
    for (genvar i = 0; i < NMOT; i++) begin : g_motor
        qmm_motor u_motor (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (motor_ctl),
            .mix     (mix[i]),
            .motor   (motor[i])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {!tick.motors_off, motor[3], motor[2], motor[1], motor[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg};

    // A switched-off result carries zero on every motor
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg[60] |-> m_data_reg[59:0] == '0)
        else $error("motors off but a motor field is non-zero");

    // Every motor field stays within full scale
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[14:0] <= OUT_W'(ONE_Q)) &&
                        (m_data_reg[29:15] <= OUT_W'(ONE_Q)) &&
                        (m_data_reg[44:30] <= OUT_W'(ONE_Q)) &&
                        (m_data_reg[59:45] <= OUT_W'(ONE_Q)))
        else $error("motor value above full scale");

    // A tick held in the input stage by a stalled output is not lost
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        tick.valid && !out_free |=> tick.valid && $stable(tick))
        else $error("input stage changed while the output was stalled");

    // A tick leaving the input stage always shows up as a result
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced tick did not reach the output register");

endmodule

[src/qmm_throttle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad motor mixer input stage
// Unpacks an input request, rescales the throttle stick and decides whether
// the motors are off, then holds the result in the input register.
// ----------------------------------------------------------------------------
module qmm_throttle
    import qmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: throttle_stick[14:0], roll_cmd[30:15], pitch_cmd[46:31],
    //          yaw_cmd[62:47], failsafe[63]
    input  logic [63:0] s_tdata,
    input  logic        out_free,
    output tick_t       tick
);

    logic [STICK_W-1:0]      stick;
    logic                    failsafe;
    logic [STICK_W-1:0]      diff;
    logic [SCALED_W-1:0]     scaled;
    logic [PROD_W-1:0]       prod;
    logic [THR_W-1:0]        thr;
    logic                    valid_reg;
    tick_t                   data_reg;
    tick_t                   data_next;

    assign stick    = s_tdata[14:0];
    assign failsafe = s_tdata[63];

    // Throttle = floor((stick - tenth) * 10 / 9); the divide by nine is a
    // reciprocal multiply that is exact over the whole stick range.
    always_comb begin
        diff   = stick - STICK_W'(TENTH_Q);
        scaled = (SCALED_W'(diff) << 3) + (SCALED_W'(diff) << 1);
        prod   = PROD_W'(scaled) * PROD_W'(DIV9_M);
        if (stick < STICK_W'(TENTH_Q)) begin
            thr = '0;
        end else begin
            thr = prod[DIV9_SHIFT +: THR_W];
        end
    end

    always_comb begin
        data_next            = '0;
        data_next.valid      = 1'b1;
        data_next.motors_off = failsafe || (thr < THR_W'(MILLI_Q));
        data_next.throttle   = thr;
        data_next.roll       = s_tdata[30:15];
        data_next.pitch      = s_tdata[46:31];
        data_next.yaw        = s_tdata[62:47];
    end

    // The stage takes a new request whenever it is empty or drains this cycle
    assign s_tready = !valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        tick       = data_reg;
        tick.valid = valid_reg;
    end

endmodule

[src/qmm_motor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad motor mixer motor channel
// Three-tap Hann smoothing, clip feedforward and output saturation for one
// motor, with the filter history and carried excess of that motor.
// ----------------------------------------------------------------------------
module qmm_motor
    import qmm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  motor_ctl_t              ctl,
    input  logic signed [MIX_W-1:0] mix,
    output logic [OUT_W-1:0]        motor
);

    logic signed [MIX_W-1:0]  prev_reg;
    logic signed [MIX_W-1:0]  prev2_reg;
    logic [CARRY_W-1:0]       carry_reg;
    logic [CARRY_W-1:0]       carry_next;
    logic signed [HSUM_W-1:0] hsum;
    logic signed [MIX_W-1:0]  filt;
    logic signed [CLIP_W-1:0] fw;
    logic signed [CLIP_W-1:0] cw;
    logic signed [CLIP_W-1:0] capw;
    logic signed [CLIP_W-1:0] one;
    logic signed [CLIP_W-1:0] excess;
    logic signed [CLIP_W-1:0] topped;
    logic signed [CLIP_W-1:0] clip_v;

    // Hann filter: floor((x + 2*prev + prev2) / 4)
    always_comb begin
        hsum = HSUM_W'(mix) + (HSUM_W'(prev_reg) <<< 1) + HSUM_W'(prev2_reg);
        filt = ctl.cfg.filter_en ? hsum[HSUM_W-1:2] : mix;
    end

    // Clip feedforward: excess above full scale is stored, capped, and added
    // back on later requests until it is used up.
    always_comb begin
        fw         = CLIP_W'(filt);
        cw         = CLIP_W'({1'b0, carry_reg});
        capw       = CLIP_W'({1'b0, ctl.cfg.clip_cap});
        one        = CLIP_W'(ONE_Q);
        excess     = cw + fw - one;
        topped     = fw + cw;
        clip_v     = fw;
        carry_next = carry_reg;
        if (ctl.cfg.clip_en) begin
            if (fw > one) begin
                carry_next = (excess > capw) ? ctl.cfg.clip_cap : excess[CARRY_W-1:0];
            end else if (carry_reg != '0) begin
                clip_v = topped;
                if (topped > one) begin
                    carry_next = excess[CARRY_W-1:0];
                end else begin
                    carry_next = '0;
                end
            end
        end
    end

    // Saturate to 0..1; a switched-off tick drives zero
    always_comb begin
        if (ctl.motors_off || (clip_v < 0)) begin
            motor = '0;
        end else if (clip_v > one) begin
            motor = OUT_W'(ONE_Q);
        end else begin
            motor = clip_v[OUT_W-1:0];
        end
    end

    // History and carry move only when a request passes to the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            prev2_reg <= '0;
            carry_reg <= '0;
        end else if (ctl.advance) begin
            if (ctl.cfg.filter_en) begin
                prev2_reg <= prev_reg;
                prev_reg  <= ctl.motors_off ? '0 : mix;
            end
            if (ctl.cfg.clip_en && !ctl.motors_off) begin
                carry_reg <= carry_next;
            end
        end
    end

endmodule

[test/quad_motor_mix_filter_clip_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad motor mixer testbench
// Drives control ticks into the X-frame mixer and predicts each motor result
// cycle-free: throttle rescale, mix, Hann smoothing and clip feedforward are
// modelled here with their own filter history and carried excess. Results are
// compared in order, field by field. Registers are written over APB between
// phases and read back. Directed ticks cover thresholds, saturation, failsafe,
// the filter and the carry; random ticks then run under varied idling and a
// long output stall.
// ----------------------------------------------------------------------------
module quad_motor_mix_filter_clip_test;
    import qmm_pkg::*;

    // One motor result as it appears in m_tdata[60:0]
    typedef struct packed {
        logic                       motors_on;
        logic [3:0][OUT_W-1:0]      drive;
    } motors_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the configuration and per-motor state
    bit          filt_en;
    bit          clip_en;
    int          cap_q = CLIP_CAP_RESET;
    int          hann_p [4];
    int          hann_p2 [4];
    int          carry [4];

    motors_t     drive_q [$];
    int          err_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_left = 0;

    string motor_names [4] = '{"motor_front_left", "motor_front_right",
                               "motor_back_right", "motor_back_left"};
    string reg_names [3] = '{"filter_enable", "clip_enable", "clip_cap"};

    quad_motor_mix_filter_clip dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("quad_motor_mix_filter_clip verification failed");
        $finish;
    end

    // Works out one result and advances the filter history and carry.
    function automatic motors_t mix_tick(input logic [STICK_W-1:0] stick,
                                         input logic signed [CMD_W-1:0] roll,
                                         input logic signed [CMD_W-1:0] pitch,
                                         input logic signed [CMD_W-1:0] yaw,
                                         input logic fs);
        motors_t res;
        int thr, r, p, y, v, sum, diff, c;
        int mixv [4];
        res = '0;
        r = int'(roll);
        p = int'(pitch);
        y = int'(yaw);
        thr = (int'(stick) < TENTH_Q) ? 0 : ((int'(stick) - TENTH_Q) * 10) / 9;
        if (fs || thr < MILLI_Q) begin
            // Motors off: a zero still enters each filter history.
            if (filt_en) begin
                for (int m = 0; m < 4; m++) begin
                    hann_p2[m] = hann_p[m];
                    hann_p[m] = 0;
                end
            end
            return res;
        end
        mixv[0] = thr + r - p - y;
        mixv[1] = thr - r - p + y;
        mixv[2] = thr - r + p - y;
        mixv[3] = thr + r + p + y;
        for (int m = 0; m < 4; m++) begin
            v = mixv[m];
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            if (filt_en) begin
                sum = v + 2 * hann_p[m] + hann_p2[m];
                hann_p2[m] = hann_p[m];
                hann_p[m] = v;
                v = sum >>> 2;
            end
            if (clip_en) begin
                if (v > ONE_Q) begin
                    c = carry[m] + (v - ONE_Q);
                    carry[m] = (c > cap_q) ? cap_q : c;
                end else if (carry[m] > 0) begin
                    diff = ONE_Q - v;
                    v = v + carry[m];
                    if (v > ONE_Q) begin
                        c = carry[m] - diff;
                        carry[m] = (c < 0) ? 0 : c;
                    end else begin
                        carry[m] = 0;
                    end
                end
            end
            if (v < 0) v = 0;
            if (v > ONE_Q) v = ONE_Q;
            res.drive[m] = OUT_W'(v);
        end
        res.motors_on = 1'b1;
        return res;
    endfunction

    // The receiver stalls at random, or for a counted stretch when asked.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        motors_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[60:0];
            if (drive_q.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                err_count++;
            end else begin
                want = drive_q.pop_front();
                for (int m = 0; m < 4; m++) begin
                    if (got.drive[m] !== want.drive[m]) begin
                        $error("%s: expected %0d, got %0d", motor_names[m],
                               want.drive[m], got.drive[m]);
                        err_count++;
                    end
                end
                if (got.motors_on !== want.motors_on) begin
                    $error("motors_on: expected %0d, got %0d", want.motors_on,
                           got.motors_on);
                    err_count++;
                end
            end
        end
    end

    // Offers one request, with random gaps before it, and predicts its result.
    task automatic send_tick(input logic [STICK_W-1:0] stick,
                             input logic signed [CMD_W-1:0] roll,
                             input logic signed [CMD_W-1:0] pitch,
                             input logic signed [CMD_W-1:0] yaw,
                             input logic fs);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {fs, yaw, pitch, roll, stick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        drive_q.push_back(mix_tick(stick, roll, pitch, yaw, fs));
    endtask

    // Stops sending and waits for every outstanding result.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input logic [CFG_IDX_W-1:0] idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== 32'(value)) begin
            $error("%s readback: expected %0d, got %0d", reg_names[idx], value, rd);
            err_count++;
        end
    endtask

    // Register writes only happen with the block drained.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [31:0] rd;
        settle_idle();
        apb_access(idx, 1'b1, 32'(value), rd);
        case (idx)
            REG_FILTER_ENABLE: filt_en = value[0];
            REG_CLIP_ENABLE:   clip_en = value[0];
            REG_CLIP_CAP:      cap_q = value & 32'h7FFF;
            default: ;
        endcase
        check_reg(idx, value);
    endtask

    function automatic logic signed [CMD_W-1:0] rand_cmd();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = int'($urandom_range(4096)) - 2048;
            6, 7:             v = int'($urandom_range(16384)) - 8192;
            default:          v = int'($urandom());
        endcase
        return CMD_W'(v);
    endfunction

    function automatic logic [STICK_W-1:0] rand_stick();
        int v;
        case ($urandom_range(9))
            0:       v = $urandom_range(1700);
            1, 2, 3, 4, 5, 6: v = $urandom_range(TENTH_Q, ONE_Q);
            7:       v = $urandom_range(12000, ONE_Q);
            8:       v = ONE_Q;
            default: v = $urandom_range(32767);
        endcase
        return STICK_W'(v);
    endfunction

    task automatic test_register_reset();
        check_reg(REG_FILTER_ENABLE, 0);
        check_reg(REG_CLIP_ENABLE, 0);
        check_reg(REG_CLIP_CAP, CLIP_CAP_RESET);
    endtask

    // Throttle thresholds, full scale, stick above full scale, failsafe and
    // each axis of the mix, with the filter and the carry both off.
    task automatic test_mix_directed();
        send_tick(0, 0, 0, 0, 0);
        send_tick(TENTH_Q - 1, 0, 0, 0, 0);
        send_tick(TENTH_Q, 0, 0, 0, 0);
        send_tick(1652, 0, 0, 0, 0);
        send_tick(1653, 0, 0, 0, 0);
        send_tick(ONE_Q, 0, 0, 0, 0);
        send_tick(15'h7FFF, 0, 0, 0, 0);
        send_tick(ONE_Q, 0, 0, 0, 1);
        send_tick(8192, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 0);
        send_tick(8192, -16'sh8000, 16'sh7FFF, -16'sh8000, 0);
        send_tick(8192, 1000, 0, 0, 0);
        send_tick(8192, 0, 1000, 0, 0);
        send_tick(8192, 0, 0, 1000, 0);
    endtask

    // Step response of the smoothing, zeros pushed while motors are off, and
    // the floor of a negative sum.
    task automatic test_filter_directed();
        set_reg(REG_FILTER_ENABLE, 1);
        send_tick(ONE_Q, 0, 0, 0, 0);
        send_tick(ONE_Q, 0, 0, 0, 0);
        send_tick(ONE_Q, 0, 0, 0, 0);
        send_tick(ONE_Q, 0, 0, 0, 1);
        send_tick(8192, -16'sh8000, 0, 0, 0);
        send_tick(1000, 0, 0, 0, 0);
        send_tick(12000, 3, -5, 7, 0);
        send_tick(12000, 3, -5, 7, 0);
        set_reg(REG_FILTER_ENABLE, 0);
    endtask

    // Excess carried forward, spent, capped, and left above a lowered cap.
    task automatic test_clip_directed();
        set_reg(REG_CLIP_ENABLE, 1);
        set_reg(REG_CLIP_CAP, ONE_Q);
        send_tick(ONE_Q, 8192, 0, 0, 0);
        send_tick(8192, 0, 0, 0, 0);
        send_tick(15'h7FFF, 0, 0, 0, 0);
        set_reg(REG_CLIP_CAP, 100);
        send_tick(4096, 0, 0, 0, 0);
        send_tick(15'h7FFF, 0, 0, 0, 0);
        set_reg(REG_CLIP_CAP, 0);
        send_tick(15'h7FFF, 0, 0, 0, 0);
        set_reg(REG_CLIP_CAP, 32767);
        send_tick(15'h7FFF, 0, 0, 0, 0);
        send_tick(15'h7FFF, 0, 0, 0, 0);
        send_tick(1700, 0, 0, 0, 0);
        set_reg(REG_CLIP_ENABLE, 0);
    endtask

    // Random ticks over four register settings under one idling pattern.
    task automatic test_random_ticks(input int count, input int tx_pct, input int rx_pct);
        int cap_pick;
        settle_idle();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(2))
                0:       cap_pick = 0;
                1:       cap_pick = 32767;
                default: cap_pick = $urandom_range(ONE_Q);
            endcase
            set_reg(REG_FILTER_ENABLE, k % 2);
            set_reg(REG_CLIP_ENABLE, (k >= 2) ? 1 : $urandom_range(1));
            set_reg(REG_CLIP_CAP, (k == 2) ? ONE_Q : cap_pick);
            for (int i = 0; i < count / 4; i++) begin
                send_tick(rand_stick(), rand_cmd(), rand_cmd(), rand_cmd(),
                          ($urandom_range(19) == 0));
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        settle_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_reg(REG_FILTER_ENABLE, 1);
        set_reg(REG_CLIP_ENABLE, 1);
        hold_left = 300;
        for (int i = 0; i < 40; i++) begin
            send_tick(rand_stick(), rand_cmd(), rand_cmd(), rand_cmd(), 1'b0);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_mix_directed();
        test_filter_directed();
        test_clip_directed();
        test_random_ticks(520, 9, 87);
        test_random_ticks(520, 87, 9);
        test_random_ticks(520, 0, 0);
        test_backpressure();
        settle_idle();
        repeat (16) @(posedge aclk);
        if (err_count == 0) begin
            $display("quad_motor_mix_filter_clip verification clean");
        end else begin
            $display("quad_motor_mix_filter_clip verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/qmm_pkg.sv
src/qmm_throttle.sv
src/qmm_motor.sv
src/quad_motor_mix_filter_clip.sv
test/quad_motor_mix_filter_clip_test.sv
